FILE: rtl/scpa_pkg.sv
// Shared types and constants of the Slater-Condon pair accumulator.
package scpa_pkg;

	localparam int DEF_MAX_ORBITALS = 64;
	localparam int DEF_ACC_WIDTH    = 48;

	localparam int CFG_W       = 7;
	localparam int OP_W        = 2;
	localparam int IN_DATA_W   = 176;
	localparam int OUT_DATA_W  = 72;
	localparam int ENTRY_W     = 48;
	localparam int WEIGHT_W    = 32;
	localparam int INDEX_W     = 6;
	localparam int RANK_W      = 7;

	localparam logic [CFG_W-1:0] ORBITALS_RESET = 7'd64;

	localparam logic [OP_W-1:0] OP_ACCUM = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIAG,
		ST_SCAN,
		ST_DECIDE,
		ST_RMW_RD,
		ST_DRAIN,
		ST_READ,
		ST_READ_DATA,
		ST_DONE
	} scpa_state_t;

endpackage

FILE: rtl/scpa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module scpa_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/slater_condon_pair_accumulator_core.sv
// Top level of the Slater-Condon one-electron pair accumulator.
// An accumulate transaction with equal masked occupancies walks the active orbitals one per
// cycle and adds the weight to each occupied diagonal entry through a single saturating adder
// in a read-modify-write pipeline. Any other accumulate transaction scans the active orbitals
// one per cycle to find the rank, the removed and added orbitals and the phase, and a single
// excitation then does one read-modify-write. A zero weight or an unused operation goes
// straight to the result. A clear transaction writes zeros to the MAX_ORBITALS x MAX_ORBITALS
// store one entry per cycle, and the same clearing pass runs after reset with s_tready low;
// the configuration port is always open. A finished result waits in the output register, so
// the next transaction is accepted while the previous result is still pending.
module slater_condon_pair_accumulator_core #(
	parameter int MAX_ORBITALS      = scpa_pkg::DEF_MAX_ORBITALS,
	parameter int ACCUMULATOR_WIDTH = scpa_pkg::DEF_ACC_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [scpa_pkg::CFG_W-1:0]       cfg_wdata,  // orbitals_in_use
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// left_occupancy, right_occupancy, pair_weight, read_row, read_column, zero pad
	input  logic [scpa_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [scpa_pkg::OP_W-1:0]        s_tuser,    // operation
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status, excitation_rank, phase_negative, added_orbital, vacated_orbital,
	// entry_value, saturated, zero pad
	output logic [scpa_pkg::OUT_DATA_W-1:0]  m_tdata
);

	import scpa_pkg::*;

	localparam int ORB_W  = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;
	localparam int DEPTH  = MAX_ORBITALS * MAX_ORBITALS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ACC_W  = ACCUMULATOR_WIDTH;
	localparam int SUM_W  = ((ACC_W > WEIGHT_W + 1) ? ACC_W : WEIGHT_W + 1) + 1;
	localparam int EXT_W  = (ACC_W > ENTRY_W) ? ACC_W : ENTRY_W;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = ~SUM_MAX;
	localparam logic signed [EXT_W-1:0] OUT_MAX =
		{{(EXT_W-ENTRY_W+1){1'b0}}, {(ENTRY_W-1){1'b1}}};
	localparam logic signed [EXT_W-1:0] OUT_MIN = ~OUT_MAX;
	localparam logic [CFG_W-1:0]  N_MAX     = CFG_W'(MAX_ORBITALS);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	// Input fields
	logic [63:0]                in_left;
	logic [63:0]                in_right;
	logic signed [WEIGHT_W-1:0] in_weight;
	logic [INDEX_W-1:0]         in_row;
	logic [INDEX_W-1:0]         in_col;

	assign in_left   = s_tdata[63:0];
	assign in_right  = s_tdata[127:64];
	assign in_weight = s_tdata[159:128];
	assign in_row    = s_tdata[165:160];
	assign in_col    = s_tdata[171:166];

	scpa_state_t state_q, state_d;

	logic [CFG_W-1:0]         cfg_q;
	logic [CFG_W-1:0]         n_eff;
	logic [MAX_ORBITALS-1:0]  act_mask;
	logic [MAX_ORBITALS-1:0]  left_m;
	logic [MAX_ORBITALS-1:0]  right_m;
	logic                     accept;
	logic                     out_load;

	logic [ORB_W-1:0]         idx_q;
	logic [ORB_W-1:0]         nlast_q;
	logic [MAX_ORBITALS-1:0]  left_q;
	logic [MAX_ORBITALS-1:0]  right_q;
	logic signed [WEIGHT_W:0] wv_q;
	logic [INDEX_W-1:0]       row_q;
	logic [INDEX_W-1:0]       col_q;
	logic [RANK_W-1:0]        nrem_q;
	logic [RANK_W-1:0]        nadd_q;
	logic [ORB_W-1:0]         a_q;
	logic [ORB_W-1:0]         r_q;
	logic                     par_r_q;
	logic                     par_a_q;
	logic                     cr_par_q;
	logic                     crl_par_q;
	logic                     status_q;
	logic                     rank1_q;
	logic                     sat_q;
	logic [ENTRY_W-1:0]       entry_q;
	logic                     item_q;
	logic [ADDR_W-1:0]        clr_q;
	logic                     pend_s1;
	logic [ADDR_W-1:0]        paddr_s1;
	logic                     m_tvalid_q;
	logic [OUT_DATA_W-1:0]    m_tdata_q;

	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_waddr;
	logic [ACC_W-1:0]         ram_wdata;
	logic                     ram_re;
	logic [ADDR_W-1:0]        ram_raddr;
	logic [ACC_W-1:0]         ram_rdata;

	logic signed [SUM_W-1:0]  sum;
	logic                     sat_hit;
	logic [ACC_W-1:0]         sum_clamped;
	logic signed [EXT_W-1:0]  rd_ext;
	logic [ENTRY_W-1:0]       rd_clamped;
	logic                     row_ok;
	logic                     neg;
	logic                     scan_rem;
	logic                     scan_add;
	logic [ADDR_W-1:0]        diag_addr;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [INDEX_W-1:0] row,
			input logic [INDEX_W-1:0] col);
		cell_addr = ADDR_W'(int'(row) * MAX_ORBITALS + int'(col));
	endfunction

	// Active orbital count and occupancy masking
	always_comb begin
		if (cfg_q == '0) begin
			n_eff = CFG_W'(1);
		end else if (cfg_q > N_MAX) begin
			n_eff = N_MAX;
		end else begin
			n_eff = cfg_q;
		end
		for (int k = 0; k < MAX_ORBITALS; k++) begin
			act_mask[k] = CFG_W'(k) < n_eff;
		end
	end

	assign left_m  = in_left[MAX_ORBITALS-1:0] & act_mask;
	assign right_m = in_right[MAX_ORBITALS-1:0] & act_mask;

	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	assign neg       = par_r_q ^ par_a_q;
	assign scan_rem  = right_q[0] && !left_q[0];
	assign scan_add  = left_q[0] && !right_q[0];
	assign diag_addr = ADDR_W'(int'(idx_q) * (MAX_ORBITALS + 1));
	assign row_ok    = (int'(row_q) < MAX_ORBITALS) && (int'(col_q) < MAX_ORBITALS);

	// Shared saturating adder used by every read-modify-write
	always_comb begin
		sum     = SUM_W'($signed(ram_rdata)) + SUM_W'(wv_q);
		sat_hit = (sum > SUM_MAX) || (sum < SUM_MIN);
		if (sum > SUM_MAX) begin
			sum_clamped = SUM_MAX[ACC_W-1:0];
		end else if (sum < SUM_MIN) begin
			sum_clamped = SUM_MIN[ACC_W-1:0];
		end else begin
			sum_clamped = sum[ACC_W-1:0];
		end
	end

	// Clamp of a stored entry to the output range
	always_comb begin
		rd_ext = EXT_W'($signed(ram_rdata));
		if (rd_ext > OUT_MAX) begin
			rd_clamped = OUT_MAX[ENTRY_W-1:0];
		end else if (rd_ext < OUT_MIN) begin
			rd_clamped = OUT_MIN[ENTRY_W-1:0];
		end else begin
			rd_clamped = rd_ext[ENTRY_W-1:0];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR) begin
					state_d = item_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (s_tuser)
						OP_ACCUM: begin
							if (in_weight == '0) begin
								state_d = ST_DONE;
							end else if (left_m == right_m) begin
								state_d = ST_DIAG;
							end else begin
								state_d = ST_SCAN;
							end
						end
						OP_READ:  state_d = ST_READ;
						OP_CLEAR: state_d = ST_CLEAR;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_DIAG: begin
				if (idx_q == nlast_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_SCAN: begin
				if (idx_q == nlast_q) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (nrem_q == nadd_q && nrem_q == RANK_W'(1)) begin
					state_d = ST_RMW_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_RMW_RD:    state_d = ST_DRAIN;
			ST_DRAIN:     state_d = ST_DONE;
			ST_READ:      state_d = ST_READ_DATA;
			ST_READ_DATA: state_d = ST_DONE;
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory control and handshake outputs
	always_comb begin
		s_tready  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = pend_s1;
		ram_waddr = paddr_s1;
		ram_wdata = sum_clamped;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: s_tready = 1'b1;
			ST_DIAG: begin
				ram_re    = left_q[0];
				ram_raddr = diag_addr;
			end
			ST_RMW_RD: begin
				ram_re    = 1'b1;
				ram_raddr = cell_addr(INDEX_W'(a_q), INDEX_W'(r_q));
			end
			ST_READ: begin
				ram_re    = 1'b1;
				ram_raddr = cell_addr(row_q, col_q);
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cfg_q      <= ORBITALS_RESET;
			clr_q      <= '0;
			idx_q      <= '0;
			pend_s1    <= 1'b0;
			item_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				cfg_q <= cfg_wdata;
			end
			if (accept) begin
				clr_q <= '0;
			end else if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				idx_q <= '0;
			end else if (state_q == ST_DIAG || state_q == ST_SCAN) begin
				idx_q <= idx_q + 1'b1;
			end
			pend_s1 <= (state_q == ST_DIAG && left_q[0]) || state_q == ST_RMW_RD;
			if (accept) begin
				item_q <= 1'b1;
			end else if (out_load) begin
				item_q <= 1'b0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		paddr_s1 <= ram_raddr;
		if (accept) begin
			row_q     <= in_row;
			col_q     <= in_col;
			left_q    <= left_m;
			right_q   <= right_m;
			wv_q      <= (WEIGHT_W+1)'(in_weight);
			nlast_q   <= ORB_W'(n_eff - 1'b1);
			nrem_q    <= '0;
			nadd_q    <= '0;
			a_q       <= '0;
			r_q       <= '0;
			par_r_q   <= 1'b0;
			par_a_q   <= 1'b0;
			cr_par_q  <= 1'b0;
			crl_par_q <= 1'b0;
			status_q  <= 1'b0;
			rank1_q   <= 1'b0;
			sat_q     <= 1'b0;
			entry_q   <= '0;
		end
		if (state_q == ST_DIAG) begin
			left_q <= left_q >> 1;
		end
		// The phase counts right-side orbitals below the removed one and
		// orbitals common to both sides below the added one.
		if (state_q == ST_SCAN) begin
			left_q    <= left_q >> 1;
			right_q   <= right_q >> 1;
			cr_par_q  <= cr_par_q ^ right_q[0];
			crl_par_q <= crl_par_q ^ (right_q[0] & left_q[0]);
			if (scan_rem) begin
				nrem_q <= nrem_q + 1'b1;
				if (nrem_q == '0) begin
					r_q     <= idx_q;
					par_r_q <= cr_par_q;
				end
			end
			if (scan_add) begin
				nadd_q <= nadd_q + 1'b1;
				if (nadd_q == '0) begin
					a_q     <= idx_q;
					par_a_q <= crl_par_q;
				end
			end
		end
		if (state_q == ST_DECIDE) begin
			status_q <= nrem_q != nadd_q;
			rank1_q  <= nrem_q == nadd_q && nrem_q == RANK_W'(1);
		end
		if (state_q == ST_RMW_RD && neg) begin
			wv_q <= -wv_q;
		end
		if (pend_s1 && sat_hit) begin
			sat_q <= 1'b1;
		end
		if (state_q == ST_READ_DATA) begin
			entry_q <= row_ok ? rd_clamped : '0;
		end
		if (out_load) begin
			m_tdata_q <= {2'b00, sat_q, entry_q,
				rank1_q ? INDEX_W'(r_q) : INDEX_W'(0),
				rank1_q ? INDEX_W'(a_q) : INDEX_W'(0),
				rank1_q & neg, nrem_q, status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	scpa_ram #(
		.WIDTH(ACC_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

`ifndef SYNTHESIS
	// Every pending read-modify-write must land before the block goes idle.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !ram_we)
		else $error("store write while idle");

	a_pend_source: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> ($past(state_q) == ST_DIAG || $past(state_q) == ST_RMW_RD))
		else $error("pending write without a preceding read");

	a_status_rank1: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> !(status_q && rank1_q))
		else $error("error status together with a single excitation");

	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> item_q)
		else $error("result produced without an accepted transaction");
`endif

endmodule
